[rtl/tnuv_pkg.sv]
// Shared types and constants for the triangle normal, planar UV and bounds block.
// No dependencies; included by every module of the block through a wildcard import.
package tnuv_pkg;

  // Operand width of the shared multiplier and of the given normal components.
  localparam int MUL_W = 32;
  localparam int ACC_W = 2 * MUL_W;
  // Unit normal output width (Q1.14) and its quotient magnitude width.
  localparam int UNIT_W = 16;
  localparam int QUO_W = 15;
  // Squared length threshold in units of 2^-32: 1e-8 rounded up to the grid.
  localparam logic [ACC_W-1:0] SMALL_LEN2 = 64'd43;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_MUL,
    ST_LEN_ACC,
    ST_LEN_CHK,
    ST_EDGE,
    ST_ESHIFT,
    ST_CROSS_MUL,
    ST_CROSS_ACC,
    ST_NSHIFT,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

endpackage

[rtl/tnuv_mul.sv]
// Registered unsigned multiplier shared by every product of the block.
// Depends on tnuv_pkg for the operand and product widths.
module tnuv_mul
  import tnuv_pkg::*;
(
  input  logic             clk,
  input  logic [MUL_W-1:0] a,
  input  logic [MUL_W-1:0] b,
  output logic [ACC_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[rtl/triangle_normal_uv_bounds_top.sv]
// Top level of the triangle normal, planar UV and bounding box block.
// Depends on tnuv_pkg and on the shared multiplier tnuv_mul.
//
// Channel   Direction  Transfer                      Content
// s_axis    in         one triangle                  given normal, three vertices
// m_axis    out        one vertex result, 3 per tri  unit normal, UV, box, tlast on third
//
// A triangle is accepted, then the squared length of its given normal is summed; when
// the given normal is small, the edge subtractions, the edge shifts and the cross product
// follow. Then come the normalising shifts, the sum of squares, the square
// root steps, the division (a load and quotient steps per component, skipped for a
// zero normal) and the emission of each result. A given normal that is not small skips
// the edge and cross product steps and needs no normalising shift. The single registered
// multiplier and the bit-serial root and divider are why the work is done step by step.
// Reset clears the sequencer and the output valid flag and sets the box corners to an empty box.
// s_axis_tready is high only in the idle state; a stalled result holds the block.
module triangle_normal_uv_bounds_top
  import tnuv_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // From bit 0: given_normal_x/y/z (32 each), first_x/y/z, second_x/y/z,
  // third_x/y/z (COORD_WIDTH each), zero padding to whole bytes.
  input  logic [((96 + 9 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic m_axis_tlast,
  // From bit 0: unit_normal_x/y/z (16 each), tex_u, tex_v, min_x/y/z, max_x/y/z
  // (COORD_WIDTH each).
  output logic [3 * UNIT_W + 8 * COORD_WIDTH - 1:0] m_axis_tdata
);

  localparam int CW = COORD_WIDTH;
  // Edge magnitudes are held at least 32 bits wide so the shift test is uniform.
  localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam logic [ACC_W-1:0] NORM_LIM = 64'h0000_0000_8000_0000;

  state_t state, state_next;

  logic [CW-1:0]     pos [3][3];
  logic [ACC_W-1:0]  mag [3];
  logic              neg [3];
  logic [EW-1:0]     em [2][3];
  logic              en [2][3];
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  root;
  logic [ACC_W-1:0]  bitr;
  logic [46:0]       rem;
  logic [46:0]       den;
  logic [QUO_W-1:0]  quo;
  logic [3:0]        qcnt;
  logic [2:0]        cnt;
  logic              ek;
  logic [1:0]        ei;
  logic [1:0]        vk;
  logic [UNIT_W-1:0] unit [3];
  logic [CW-1:0]     lo [3];
  logic [CW-1:0]     hi [3];
  logic [CW-1:0]     tex_u;
  logic [CW-1:0]     tex_v;
  logic              out_valid;
  logic              out_last;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [ACC_W-1:0]  prod;
  logic              xneg;
  logic [ACC_W-1:0]  sprod;
  logic [ACC_W-1:0]  cross_val;
  logic              eshift_any;
  logic              nshift_any;
  logic [ACC_W-1:0]  sq_try;
  logic [ACC_W-1:0]  root_step;
  logic              div_ge;
  logic [QUO_W-1:0]  quo_done;
  logic [CW:0]       edge_diff;
  logic [CW:0]       edge_mag;
  logic [UNIT_W-1:0] ux, uy, uz;

  tnuv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Operand selection for the shared multiplier. The cross product terms are
  // c0 = e01*e12 - e02*e11, c1 = e02*e10 - e00*e12, c2 = e00*e11 - e01*e10.
  always_comb begin
    mul_a = mag[cnt[1:0]][MUL_W-1:0];
    mul_b = mag[cnt[1:0]][MUL_W-1:0];
    xneg  = 1'b0;
    if (state == ST_CROSS_MUL || state == ST_CROSS_ACC) begin
      case (cnt)
        3'd0:    begin mul_a = em[0][1][31:0]; mul_b = em[1][2][31:0];
                       xneg = en[0][1] ^ en[1][2]; end
        3'd1:    begin mul_a = em[0][2][31:0]; mul_b = em[1][1][31:0];
                       xneg = en[0][2] ^ en[1][1]; end
        3'd2:    begin mul_a = em[0][2][31:0]; mul_b = em[1][0][31:0];
                       xneg = en[0][2] ^ en[1][0]; end
        3'd3:    begin mul_a = em[0][0][31:0]; mul_b = em[1][2][31:0];
                       xneg = en[0][0] ^ en[1][2]; end
        3'd4:    begin mul_a = em[0][0][31:0]; mul_b = em[1][1][31:0];
                       xneg = en[0][0] ^ en[1][1]; end
        default: begin mul_a = em[0][1][31:0]; mul_b = em[1][0][31:0];
                       xneg = en[0][1] ^ en[1][0]; end
      endcase
    end
  end

  always_comb begin
    sprod      = xneg ? (64'd0 - prod) : prod;
    cross_val  = acc - sprod;
    eshift_any = 1'b0;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (em[k][i][EW-1:31] != '0) eshift_any = 1'b1;
      end
    end
    nshift_any = (mag[0] > NORM_LIM) || (mag[1] > NORM_LIM) || (mag[2] > NORM_LIM);
    sq_try     = root + bitr;
    root_step  = (acc >= sq_try) ? ((root >> 1) + bitr) : (root >> 1);
    div_ge     = rem >= den;
    quo_done   = {quo[QUO_W-2:0], div_ge};
    edge_diff  = {pos[ek ? 2'd2 : 2'd1][ei][CW-1], pos[ek ? 2'd2 : 2'd1][ei]}
               - {pos[0][ei][CW-1], pos[0][ei]};
    edge_mag   = edge_diff[CW] ? (~edge_diff + 1'b1) : edge_diff;
    ux = unit[0][UNIT_W-1] ? (16'd0 - unit[0]) : unit[0];
    uy = unit[1][UNIT_W-1] ? (16'd0 - unit[1]) : unit[1];
    uz = unit[2][UNIT_W-1] ? (16'd0 - unit[2]) : unit[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_axis_tvalid) state_next = ST_LEN_MUL;
      ST_LEN_MUL:   state_next = ST_LEN_ACC;
      ST_LEN_ACC:   state_next = (cnt == 3'd2) ? ST_LEN_CHK : ST_LEN_MUL;
      ST_LEN_CHK:   state_next = (acc < SMALL_LEN2) ? ST_EDGE : ST_NSHIFT;
      ST_EDGE:      if (ek && ei == 2'd2) state_next = ST_ESHIFT;
      ST_ESHIFT:    if (!eshift_any) state_next = ST_CROSS_MUL;
      ST_CROSS_MUL: state_next = ST_CROSS_ACC;
      ST_CROSS_ACC: state_next = (cnt == 3'd5) ? ST_NSHIFT : ST_CROSS_MUL;
      ST_NSHIFT:    if (!nshift_any) state_next = ST_SQ_MUL;
      ST_SQ_MUL:    state_next = ST_SQ_ACC;
      ST_SQ_ACC:    state_next = (cnt == 3'd2) ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT: begin
        if (bitr == 64'd1) state_next = (root_step == '0) ? ST_EMIT_LOAD : ST_DIV_LOAD;
      end
      ST_DIV_LOAD:  state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (qcnt == 4'd14) state_next = (cnt == 3'd2) ? ST_EMIT_LOAD : ST_DIV_LOAD;
      end
      ST_EMIT_LOAD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (m_axis_tready) state_next = (vk == 2'd2) ? ST_IDLE : ST_EMIT_LOAD;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Datapath registers, stepped by the sequencer state.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
              pos[k][i] <= s_axis_tdata[96 + (3 * k + i) * CW +: CW];
            end
          end
          for (int i = 0; i < 3; i++) begin
            mag[i] <= {32'd0, s_axis_tdata[32 * i + 31]
                       ? (32'd0 - s_axis_tdata[32 * i +: 32]) : s_axis_tdata[32 * i +: 32]};
            neg[i] <= s_axis_tdata[32 * i + 31];
          end
          cnt <= '0;
          acc <= '0;
        end
      end
      ST_LEN_ACC, ST_SQ_ACC: begin
        acc <= acc + prod;
        cnt <= cnt + 3'd1;
      end
      ST_LEN_CHK: begin
        ek <= 1'b0;
        ei <= '0;
      end
      ST_EDGE: begin
        em[ek][ei] <= EW'(edge_mag[CW-1:0]);
        en[ek][ei] <= edge_diff[CW];
        if (ei == 2'd2) begin
          ei <= '0;
          ek <= 1'b1;
        end else begin
          ei <= ei + 2'd1;
        end
      end
      ST_ESHIFT: begin
        if (eshift_any) begin
          for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) em[k][i] <= em[k][i] >> 1;
          end
        end
        cnt <= '0;
      end
      ST_CROSS_ACC: begin
        if (!cnt[0]) begin
          acc <= sprod;
        end else begin
          mag[cnt[2:1]] <= cross_val[ACC_W-1] ? (64'd0 - cross_val) : cross_val;
          neg[cnt[2:1]] <= cross_val[ACC_W-1];
        end
        cnt <= cnt + 3'd1;
      end
      ST_NSHIFT: begin
        if (nshift_any) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end
        cnt  <= '0;
        acc  <= '0;
        root <= '0;
        bitr <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: begin
        if (acc >= sq_try) acc <= acc - sq_try;
        root <= root_step;
        bitr <= bitr >> 2;
        cnt  <= '0;
        vk   <= '0;
        if (bitr == 64'd1 && root_step == '0) begin
          for (int i = 0; i < 3; i++) unit[i] <= '0;
        end
      end
      ST_DIV_LOAD: begin
        rem  <= {mag[cnt[1:0]][31:0], 15'd0} + {15'd0, root[31:0]};
        den  <= {root[32:0], 14'd0} << 1;
        quo  <= '0;
        qcnt <= '0;
      end
      ST_DIV_STEP: begin
        if (div_ge) rem <= rem - den;
        den  <= den >> 1;
        quo  <= quo_done;
        qcnt <= qcnt + 4'd1;
        if (qcnt == 4'd14) begin
          unit[cnt[1:0]] <= neg[cnt[1:0]] ? (16'd0 - {1'b0, quo_done})
                                          : {1'b0, quo_done};
          cnt <= cnt + 3'd1;
        end
      end
      ST_EMIT_LOAD: begin
        // Drop the dominant axis; ties go to x, then to y.
        if (ux >= uy && ux >= uz) begin
          tex_u <= pos[vk][1];
          tex_v <= pos[vk][2];
        end else if (uy >= ux && uy >= uz) begin
          tex_u <= pos[vk][0];
          tex_v <= pos[vk][2];
        end else begin
          tex_u <= pos[vk][0];
          tex_v <= pos[vk][1];
        end
        out_last <= (vk == 2'd2);
      end
      ST_EMIT_WAIT: begin
        if (m_axis_tready) vk <= vk + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Running bounding box and the output valid flag; reset clears the flag and empties the box.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo[i] <= {1'b0, {(CW - 1){1'b1}}};
        hi[i] <= {1'b1, {(CW - 1){1'b0}}};
      end
    end else begin
      if (state == ST_EMIT_LOAD) begin
        out_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          if ($signed(pos[vk][i]) < $signed(lo[i])) lo[i] <= pos[vk][i];
          if ($signed(pos[vk][i]) > $signed(hi[i])) hi[i] <= pos[vk][i];
        end
      end else if (state == ST_EMIT_WAIT && m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0], tex_v, tex_u,
                          unit[2], unit[1], unit[0]};

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(lo[0]) <= $signed(hi[0]) && $signed(lo[1]) <= $signed(hi[1])
                       && $signed(lo[2]) <= $signed(hi[2])))
    else $error("bounding box minimum above maximum");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (ux <= 16'd16384 && uy <= 16'd16384 && uz <= 16'd16384))
    else $error("unit normal component out of range");

  a_root_width: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_LOAD) |-> (root[63:32] == '0 && root != '0))
    else $error("square root out of range at division start");

endmodule

[bench/tb_triangle_normal_uv_bounds_top.sv]
// Testbench for triangle_normal_uv_bounds_top: drives triangles over the input stream and
// checks every vertex result against an in-bench predictor of normal, planar UV and box.
// Depends on tnuv_pkg and the block's RTL only.
module tb_triangle_normal_uv_bounds_top;
  import tnuv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int IN_W = ((96 + 9 * CW + 7) / 8) * 8;
  localparam int OUT_W = 3 * UNIT_W + 8 * CW;
  localparam int N_RANDOM = 450;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic             last;
    logic [OUT_W-1:0] data;
  } vertex_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic m_axis_tlast;
  logic [OUT_W-1:0] m_axis_tdata;

  triangle_normal_uv_bounds_top #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the running box corners, and the results still owed by the block.
  logic signed [CW-1:0] box_low [3];
  logic signed [CW-1:0] box_high [3];
  vertex_result_t owed_results [$];
  int error_count = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;

  function automatic logic [63:0] magnitude64(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Works out the three vertex results of one triangle and advances the box.
  task automatic predict_triangle(input logic [IN_W-1:0] tri_data);
    logic signed [63:0] pos [3][3];
    logic [63:0] am [3];
    logic neg [3];
    logic [63:0] len2, em [2][3], sum, root;
    logic en [2][3];
    logic signed [63:0] e [2][3], c [3];
    logic signed [15:0] nrm [3];
    logic [63:0] ax, ay, az, q;
    logic signed [CW-1:0] u, v;
    logic [OUT_W-1:0] d;
    vertex_result_t item;
    bit big;
    len2 = 0;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++)
        pos[k][i] = 64'($signed(tri_data[96 + (3 * k + i) * CW +: CW]));
    for (int i = 0; i < 3; i++) begin
      c[i] = 64'($signed(tri_data[32 * i +: 32]));
      am[i] = magnitude64(c[i]);
      neg[i] = c[i] < 0;
      len2 += am[i] * am[i];
    end
    // A tiny given normal is replaced by the cross product of the edges from the first vertex.
    if (len2 < SMALL_LEN2) begin
      for (int k = 0; k < 2; k++)
        for (int i = 0; i < 3; i++) begin
          en[k][i] = pos[k + 1][i] < pos[0][i];
          em[k][i] = en[k][i] ? pos[0][i] - pos[k + 1][i] : pos[k + 1][i] - pos[0][i];
        end
      big = 1'b1;
      while (big) begin
        big = 1'b0;
        for (int k = 0; k < 2; k++)
          for (int i = 0; i < 3; i++)
            if (em[k][i] >= (64'd1 << 31)) big = 1'b1;
        if (big)
          for (int k = 0; k < 2; k++)
            for (int i = 0; i < 3; i++) em[k][i] >>= 1;
      end
      for (int k = 0; k < 2; k++)
        for (int i = 0; i < 3; i++)
          e[k][i] = en[k][i] ? -$signed(em[k][i]) : $signed(em[k][i]);
      c[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
      c[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
      c[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
      for (int i = 0; i < 3; i++) begin
        am[i] = magnitude64(c[i]);
        neg[i] = c[i] < 0;
      end
    end
    while (am[0] > (64'd1 << 31) || am[1] > (64'd1 << 31) || am[2] > (64'd1 << 31))
      for (int i = 0; i < 3; i++) am[i] >>= 1;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += am[i] * am[i];
    root = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (root != 0) ? (am[i] * 64'd32768 + root) / (2 * root) : 64'd0;
      nrm[i] = neg[i] ? -q[15:0] : q[15:0];
    end
    ax = magnitude64(64'(nrm[0]));
    ay = magnitude64(64'(nrm[1]));
    az = magnitude64(64'(nrm[2]));
    for (int k = 0; k < 3; k++) begin
      if (ax >= ay && ax >= az) begin
        u = CW'(pos[k][1]); v = CW'(pos[k][2]);
      end else if (ay >= ax && ay >= az) begin
        u = CW'(pos[k][0]); v = CW'(pos[k][2]);
      end else begin
        u = CW'(pos[k][0]); v = CW'(pos[k][1]);
      end
      for (int i = 0; i < 3; i++) begin
        if (pos[k][i] < box_low[i]) box_low[i] = CW'(pos[k][i]);
        if (pos[k][i] > box_high[i]) box_high[i] = CW'(pos[k][i]);
      end
      d = {box_high[2], box_high[1], box_high[0], box_low[2], box_low[1], box_low[0],
           v, u, nrm[2], nrm[1], nrm[0]};
      item.last = (k == 2);
      item.data = d;
      owed_results = {owed_results, item};
    end
  endtask

  // Compares one accepted vertex result with the oldest owed one, field by field.
  task automatic check_vertex(input logic last, input logic [OUT_W-1:0] got);
    vertex_result_t want;
    string names [11] = '{"unit_normal_x", "unit_normal_y", "unit_normal_z", "tex_u",
                          "tex_v", "min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
    int lo, w;
    if (owed_results.size() == 0) begin
      $error("unexpected vertex result %h", got);
      error_count++;
      return;
    end
    want = owed_results.pop_front();
    if (want.last !== last) begin
      $error("last_of_triangle: expected %0d, got %0d", want.last, last);
      error_count++;
    end
    for (int f = 0; f < 11; f++) begin
      lo = f < 3 ? 16 * f : 48 + (f - 3) * CW;
      w = f < 3 ? 16 : CW;
      if (((want.data ^ got) >> lo) & ((64'd1 << w) - 1)) begin
        $error("%s: expected %h, got %h", names[f],
               (want.data >> lo) & ((64'd1 << w) - 1), (got >> lo) & ((64'd1 << w) - 1));
        error_count++;
      end
    end
  endtask

  function automatic logic [IN_W-1:0] pack_triangle(logic [31:0] f [12]);
    logic [IN_W-1:0] t;
    t = '0;
    for (int i = 0; i < 12; i++) t[32 * i +: 32] = f[i];
    return t;
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  // A random triangle: small given normals in half of the modes so the cross product path is exercised.
  function automatic logic [IN_W-1:0] random_triangle();
    logic [31:0] f [12];
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++)
      case (mode)
        0: f[i] = 32'd0;
        1: f[i] = $urandom_range(0, 8) - 4;
        2: f[i] = $urandom;
        default: f[i] = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      endcase
    for (int i = 3; i < 12; i++) f[i] = random_coord();
    // Now and then a repeated vertex makes the triangle degenerate.
    if ($urandom_range(0, 9) == 0)
      for (int i = 0; i < 3; i++) f[6 + i] = f[3 + i];
    return pack_triangle(f);
  endfunction

  // Directed rows: reset box first, extremes, tiny and zero normals, degenerates, ties.
  logic [31:0] directed_rows [14][12] = '{
    '{32'h10000, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9},
    '{0, 32'h10000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
      32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0},
    '{0, 0, 32'hffff0000, 5, 6, 7, 8, 9, 10, 11, 12, 13},
    '{0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3},
    '{3, 3, 3, 32'h80000000, 32'h80000000, 32'h80000000,
      32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 1, 1, 1, 2, 2, 2},
    '{32'h80000000, 32'h80000000, 32'h80000000, 9, 9, 9, 9, 9, 9, 9, 9, 9},
    '{32'h80000000, 32'h7fffffff, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9},
    '{32'h10000, 32'h10000, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9},
    '{0, 32'h10000, 32'h10000, 1, 2, 3, 4, 5, 6, 7, 8, 9},
    '{0, 0, 0, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0,
      32'h80000000, 32'h80000000, 32'h7fffffff},
    '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff}
  };

  // Offers one triangle at the falling edge and holds it until a transfer happens.
  task automatic send_triangle(input logic [IN_W-1:0] t);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= t;
    do @(posedge clk); while (!s_axis_tready);
    predict_triangle(t);
  endtask

  task automatic drop_valid(input int gap);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= IN_W'({$urandom, $urandom, $urandom});
    repeat (gap) @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  initial begin
    int burst;
    for (int i = 0; i < 3; i++) begin
      box_low[i] = {1'b0, {(CW - 1){1'b1}}};
      box_high[i] = {1'b1, {(CW - 1){1'b0}}};
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The first row after reset also has its unit_normal_x expectation typed in.
    send_triangle(pack_triangle(directed_rows[0]));
    owed_results[0].data[15:0] = 16'sd16384;
    for (int r = 1; r < 14; r++) begin
      send_triangle(pack_triangle(directed_rows[r]));
      if (r % 4 == 0) drop_valid($urandom_range(0, 3));
    end
    drop_valid(1);
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        drop_valid($urandom_range(0, 300));
        burst = $urandom_range(1, 12);
      end
      send_triangle(random_triangle());
      burst--;
    end
    drop_valid(0);
    stimulus_done = 1'b1;
  end

  // Receiver: its own stall pattern, plus one long hold-off early in the random part.
  initial begin
    int mode;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (3000) begin
      @(negedge clk);
      m_axis_tready <= 1'b1;
    end
    hold_off = 1'b1;
    @(negedge clk);
    m_axis_tready <= 1'b0;
    repeat (2000) @(negedge clk);
    hold_off = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 400)) begin
        @(negedge clk);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Sampling of results and the watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_vertex(m_axis_tlast, m_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // End of run: everything owed has arrived, then a drain period for stray results.
  initial begin
    wait (stimulus_done && owed_results.size() == 0);
    repeat (400) @(posedge clk);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
